// ===== rtl/fcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared widths, register indexes and control structs of the frame channel
// statistics block.
// ----------------------------------------------------------------------------
package fcs_pkg;

    localparam int DATA_W = 16;   // sample and result field width
    localparam int SUM_W  = 40;   // channel sum width
    localparam int PPF_W  = 25;   // pixel count register width
    localparam int CC_W   = 3;    // channel count register width
    localparam int CH_W   = 2;    // channel index width
    localparam int IDX_W  = 1;    // configuration register index width

    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT    = 1'd0;
    localparam logic [IDX_W-1:0] REG_PIXELS_PER_FRAME = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic acc_en;       // accumulate the accepted item
        logic div_load;     // start the mean division for lane 0
        logic div_step;     // one quotient bit
        logic shift_lanes;  // move lanes down by one channel
        logic clear_all;    // return the lanes and the channel and pixel counters to their reset values
    } fcs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic frame_end;    // the current item completes the frame
        logic div_done;     // this step gives the final quotient bit
        logic last_ch;      // the result in progress is the last of the frame
    } fcs_status_t;

endpackage

// ===== rtl/fcs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_ctrl
// Sequencer: accumulates items, then runs one division and one result
// handover per channel at the end of each frame.
// ----------------------------------------------------------------------------
module fcs_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  fcs_pkg::fcs_status_t status,
    output fcs_pkg::fcs_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_ACC  = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_take;
    logic   out_take;

    assign in_stall  = (state_reg != S_ACC);
    assign out_valid = (state_reg == S_OUT);
    assign in_take   = in_valid && (state_reg == S_ACC);
    assign out_take  = out_valid && !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        cmd.acc_en      = 1'b0;
        cmd.div_load    = 1'b0;
        cmd.div_step    = 1'b0;
        cmd.shift_lanes = 1'b0;
        cmd.clear_all   = 1'b0;
        unique case (state_reg)
            S_ACC:
            begin
                cmd.acc_en = in_take;
                if (in_take && status.frame_end)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_take)
                begin
                    if (status.last_ch)
                    begin
                        cmd.clear_all = 1'b1;
                        state_next    = S_ACC;
                    end
                    else
                    begin
                        cmd.shift_lanes = 1'b1;
                        state_next      = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // no item is taken while a result is on offer
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("item accepted while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && status.div_done |=> (state_reg == S_OUT))
        else $error("finished division did not present a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && status.last_ch |=> (state_reg == S_ACC))
        else $error("frame did not restart after its last result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !status.last_ch |=> (state_reg == S_LOAD))
        else $error("next channel division not started");

endmodule

// ===== rtl/fcs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_datapath
// Per-channel sum, minimum and maximum lanes, pixel counting, a restoring
// divider for the mean and the result register.
// ----------------------------------------------------------------------------
module fcs_datapath
#(
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  fcs_pkg::fcs_cmd_t            cmd,
    output fcs_pkg::fcs_status_t         status,
    input  logic [fcs_pkg::CC_W-1:0]     eff_channels,
    input  logic [fcs_pkg::PPF_W-1:0]    eff_pixels,
    input  logic [fcs_pkg::DATA_W-1:0]   sample,
    output logic [fcs_pkg::CH_W-1:0]     channel,
    output logic [fcs_pkg::DATA_W-1:0]   mean_value,
    output logic [fcs_pkg::DATA_W-1:0]   min_value,
    output logic [fcs_pkg::DATA_W-1:0]   max_value,
    output logic                         last_of_frame
);

    localparam int DATA_W = fcs_pkg::DATA_W;
    localparam int SUM_W  = fcs_pkg::SUM_W;
    localparam int PPF_W  = fcs_pkg::PPF_W;
    localparam int CC_W   = fcs_pkg::CC_W;
    localparam int CH_W   = fcs_pkg::CH_W;
    localparam int CMP_W  = SUM_W + 1;
    localparam int IT_W   = $clog2(SAMPLE_BITS);
    localparam logic [DATA_W-1:0] SAMPLE_MASK =
        DATA_W'((32'd1 << SAMPLE_BITS) - 32'd1);
    localparam logic [IT_W-1:0] LAST_IT = IT_W'(SAMPLE_BITS - 1);

    logic [SUM_W-1:0]  sum_reg [MAX_CHANNELS];
    logic [DATA_W-1:0] min_reg [MAX_CHANNELS];
    logic [DATA_W-1:0] max_reg [MAX_CHANNELS];
    logic [SUM_W-1:0]  sum_up  [MAX_CHANNELS];
    logic [DATA_W-1:0] min_up  [MAX_CHANNELS];
    logic [DATA_W-1:0] max_up  [MAX_CHANNELS];

    logic [CH_W-1:0]  cur_ch_reg;
    logic [PPF_W-1:0] pix_cnt_reg;
    logic [CC_W-1:0]  nc_reg;
    logic [PPF_W-1:0] np_reg;
    logic [CH_W-1:0]  out_ch_reg;

    logic [DATA_W-1:0] s;
    logic [CH_W-1:0]   ch_sel;
    logic [CC_W-1:0]   ch_inc;
    logic              pixel_done;
    logic [PPF_W-1:0]  pix_inc;

    logic [PPF_W-1:0]       rem_reg;
    logic [SAMPLE_BITS-1:0] lo_reg;
    logic [SAMPLE_BITS-1:0] q_reg;
    logic                   sat_reg;
    logic [IT_W-1:0]        it_reg;
    logic [PPF_W+1:0]       diff;
    logic                   q_bit;
    logic [PPF_W-1:0]       rem_next;
    logic [SAMPLE_BITS-1:0] q_next;
    logic [CMP_W-1:0]       np_shift;
    logic                   sat;

    logic [CH_W-1:0]   res_ch_reg;
    logic [DATA_W-1:0] res_mean_reg;
    logic [DATA_W-1:0] res_min_reg;
    logic [DATA_W-1:0] res_max_reg;
    logic              res_last_reg;

    // lane k takes over lane k+1 when a result that is not the last of the frame has gone out
    for (genvar k = 0; k < MAX_CHANNELS; k++)
    begin : g_up
        if (k == MAX_CHANNELS - 1)
        begin : g_top
            assign sum_up[k] = '0;
            assign min_up[k] = SAMPLE_MASK;
            assign max_up[k] = '0;
        end
        else
        begin : g_mid
            assign sum_up[k] = sum_reg[k+1];
            assign min_up[k] = min_reg[k+1];
            assign max_up[k] = max_reg[k+1];
        end
    end

    assign s          = DATA_W'(sample[SAMPLE_BITS-1:0]);
    assign ch_sel     = ({1'b0, cur_ch_reg} >= eff_channels) ? '0 : cur_ch_reg;
    assign ch_inc     = CC_W'(ch_sel) + CC_W'(1);
    assign pixel_done = (ch_inc >= eff_channels);
    assign pix_inc    = pix_cnt_reg + PPF_W'(1);

    assign status.frame_end = pixel_done && (pix_inc >= eff_pixels);
    assign status.div_done  = (it_reg == LAST_IT);
    assign status.last_ch   = ((CC_W'(out_ch_reg) + CC_W'(1)) == nc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_CHANNELS; k++)
            begin
                sum_reg[k] <= '0;
                min_reg[k] <= SAMPLE_MASK;
                max_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < MAX_CHANNELS; k++)
            begin
                if (cmd.clear_all)
                begin
                    sum_reg[k] <= '0;
                    min_reg[k] <= SAMPLE_MASK;
                    max_reg[k] <= '0;
                end
                else if (cmd.shift_lanes)
                begin
                    sum_reg[k] <= sum_up[k];
                    min_reg[k] <= min_up[k];
                    max_reg[k] <= max_up[k];
                end
                else if (cmd.acc_en && (ch_sel == CH_W'(k)))
                begin
                    sum_reg[k] <= sum_reg[k] + SUM_W'(s);
                    if (s < min_reg[k])
                    begin
                        min_reg[k] <= s;
                    end
                    if (s > max_reg[k])
                    begin
                        max_reg[k] <= s;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_ch_reg  <= '0;
            pix_cnt_reg <= '0;
            nc_reg      <= CC_W'(1);
            np_reg      <= PPF_W'(1);
            out_ch_reg  <= '0;
        end
        else
        begin
            if (cmd.clear_all)
            begin
                cur_ch_reg  <= '0;
                pix_cnt_reg <= '0;
            end
            else if (cmd.acc_en)
            begin
                if (pixel_done)
                begin
                    cur_ch_reg  <= '0;
                    pix_cnt_reg <= pix_inc;
                end
                else
                begin
                    cur_ch_reg <= ch_inc[CH_W-1:0];
                end
                if (status.frame_end)
                begin
                    nc_reg     <= eff_channels;
                    np_reg     <= eff_pixels;
                    out_ch_reg <= '0;
                end
            end
            else if (cmd.shift_lanes)
            begin
                out_ch_reg <= out_ch_reg + CH_W'(1);
            end
        end
    end

    // mean saturates once the quotient needs more than the sample width
    assign np_shift = CMP_W'(np_reg) << SAMPLE_BITS;
    assign sat      = ({1'b0, sum_reg[0]} >= np_shift);

    assign diff     = {1'b0, rem_reg, lo_reg[SAMPLE_BITS-1]} - {2'b00, np_reg};
    assign q_bit    = !diff[PPF_W+1];
    assign rem_next = q_bit ? diff[PPF_W-1:0]
                            : {rem_reg[PPF_W-2:0], lo_reg[SAMPLE_BITS-1]};
    assign q_next   = {q_reg[SAMPLE_BITS-2:0], q_bit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            it_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            it_reg <= it_reg + IT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            sat_reg <= sat;
            rem_reg <= PPF_W'(sum_reg[0] >> SAMPLE_BITS);
            lo_reg  <= sum_reg[0][SAMPLE_BITS-1:0];
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            lo_reg  <= lo_reg << 1;
            q_reg   <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_step && status.div_done)
        begin
            res_ch_reg   <= out_ch_reg;
            res_mean_reg <= sat_reg ? SAMPLE_MASK : DATA_W'(q_next);
            res_min_reg  <= min_reg[0];
            res_max_reg  <= max_reg[0];
            res_last_reg <= status.last_ch;
        end
    end

    assign channel       = res_ch_reg;
    assign mean_value    = res_mean_reg;
    assign min_value     = res_min_reg;
    assign max_value     = res_max_reg;
    assign last_of_frame = res_last_reg;

endmodule

// ===== rtl/frame_channel_statistics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_channel_statistics
// Per-channel mean, minimum and maximum over a frame of interleaved samples.
// ----------------------------------------------------------------------------
// throughput: one sample per cycle inside a frame
// frame end: per channel a load state and SAMPLE_BITS divider steps
// (the shared restoring divider), then the result waits for the sink
// input stalls from the last sample of a frame until its last result is taken
// reset: channel_count 3, pixels_per_frame 1, sums and maxima cleared, minima all ones
module frame_channel_statistics
#(
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 16,
    parameter int COUNT_BITS   = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [fcs_pkg::IDX_W-1:0]     cfg_index,
    input  logic [fcs_pkg::PPF_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fcs_pkg::DATA_W-1:0]    sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fcs_pkg::CH_W-1:0]      channel,
    output logic [fcs_pkg::DATA_W-1:0]    mean_value,
    output logic [fcs_pkg::DATA_W-1:0]    min_value,
    output logic [fcs_pkg::DATA_W-1:0]    max_value,
    output logic                          last_of_frame
);

    localparam int CC_W  = fcs_pkg::CC_W;
    localparam int PPF_W = fcs_pkg::PPF_W;
    localparam logic [PPF_W-1:0] COUNT_LIMIT  = PPF_W'(1) << COUNT_BITS;
    localparam logic [CC_W-1:0]  CHANNEL_LIMIT = CC_W'(MAX_CHANNELS);

    logic [CC_W-1:0]  chan_count_reg;
    logic [PPF_W-1:0] pixels_reg;
    logic [CC_W-1:0]  eff_channels;
    logic [PPF_W-1:0] eff_pixels;

    fcs_pkg::fcs_cmd_t    cmd;
    fcs_pkg::fcs_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= CC_W'(3);
            pixels_reg     <= PPF_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fcs_pkg::REG_CHANNEL_COUNT:    chan_count_reg <= cfg_data[CC_W-1:0];
                fcs_pkg::REG_PIXELS_PER_FRAME: pixels_reg     <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // out of range settings clamp to the nearest legal value
    always_comb
    begin
        if (chan_count_reg == '0)
        begin
            eff_channels = CC_W'(1);
        end
        else if (chan_count_reg > CHANNEL_LIMIT)
        begin
            eff_channels = CHANNEL_LIMIT;
        end
        else
        begin
            eff_channels = chan_count_reg;
        end

        if (pixels_reg == '0)
        begin
            eff_pixels = PPF_W'(1);
        end
        else if (pixels_reg > COUNT_LIMIT)
        begin
            eff_pixels = COUNT_LIMIT;
        end
        else
        begin
            eff_pixels = pixels_reg;
        end
    end

    fcs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fcs_datapath
    #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .eff_channels  (eff_channels),
        .eff_pixels    (eff_pixels),
        .sample        (sample),
        .channel       (channel),
        .mean_value    (mean_value),
        .min_value     (min_value),
        .max_value     (max_value),
        .last_of_frame (last_of_frame)
    );

endmodule

// ===== sim/frame_channel_statistics_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_channel_statistics_tb
// Drives interleaved samples into the statistics block and checks every
// per-channel mean, minimum and maximum against a cycle-free model of the
// frame accumulation. A short table covers extremes, register clamping and
// mid-frame register changes; randomised blocks follow, with random gaps on
// both channels, long output hold-offs and drains before each reconfiguration.
// ----------------------------------------------------------------------------
module frame_channel_statistics_tb;

    localparam int DATA_W = fcs_pkg::DATA_W;
    localparam int SUM_W  = fcs_pkg::SUM_W;
    localparam int PPF_W  = fcs_pkg::PPF_W;
    localparam int CC_W   = fcs_pkg::CC_W;
    localparam int CH_W   = fcs_pkg::CH_W;
    localparam int IDX_W  = fcs_pkg::IDX_W;

    localparam int LANES         = 4;
    localparam int SETTLE_CYCLES = LANES * (DATA_W + 2) + 16;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 500;
    localparam int BLOCK_ITEMS   = 50;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [PPF_W-1:0] PIXEL_CAP = 25'h1000000;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [DATA_W-1:0] mean_value;
        logic [DATA_W-1:0] min_value;
        logic [DATA_W-1:0] max_value;
        logic              last_of_frame;
    } stat_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [IDX_W-1:0]  index;
        logic [PPF_W-1:0]  value;
        bit                typed;
        stat_result_t      want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [PPF_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [DATA_W-1:0] sample = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CH_W-1:0]   channel;
    logic [DATA_W-1:0] mean_value;
    logic [DATA_W-1:0] min_value;
    logic [DATA_W-1:0] max_value;
    logic              last_of_frame;

    // frame model state
    logic [CC_W-1:0]   cfg_channels;
    logic [PPF_W-1:0]  cfg_pixels;
    logic [SUM_W-1:0]  chan_sum [LANES];
    logic [DATA_W-1:0] chan_min [LANES];
    logic [DATA_W-1:0] chan_max [LANES];
    int unsigned       walk_channel;
    logic [PPF_W-1:0]  pixels_done;

    stat_result_t pending_stats[$];
    stim_row_t    directed_rows[$];

    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          in_mode = 1;
    int          out_mode = 1;
    bit          long_hold_req = 1'b0;
    stat_result_t mon_got;
    stat_result_t mon_want;

    frame_channel_statistics i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel       (channel),
        .mean_value    (mean_value),
        .min_value     (min_value),
        .max_value     (max_value),
        .last_of_frame (last_of_frame)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void clear_frame_stats();
        for (int i = 0; i < LANES; i++)
        begin
            chan_sum[i] = '0;
            chan_min[i] = '1;
            chan_max[i] = '0;
        end
        walk_channel = 0;
        pixels_done  = '0;
    endfunction

    function automatic void apply_register(logic [IDX_W-1:0] idx, logic [PPF_W-1:0] data);
        if (idx == fcs_pkg::REG_CHANNEL_COUNT)
            cfg_channels = data[CC_W-1:0];
        else if (idx == fcs_pkg::REG_PIXELS_PER_FRAME)
            cfg_pixels = data;
    endfunction

    // one accepted sample; queues the frame results when it closes the frame
    function automatic void account_sample(logic [DATA_W-1:0] s);
        int unsigned      nc;
        int unsigned      ch;
        logic [PPF_W-1:0] np;
        logic [SUM_W-1:0] quotient;
        stat_result_t     r;
        nc = (cfg_channels == 0) ? 1 : (cfg_channels > LANES) ? LANES : cfg_channels;
        np = (cfg_pixels == 0) ? 25'd1 : (cfg_pixels > PIXEL_CAP) ? PIXEL_CAP : cfg_pixels;
        ch = (walk_channel >= nc) ? 0 : walk_channel;
        chan_sum[ch] = chan_sum[ch] + SUM_W'(s);
        if (s < chan_min[ch])
            chan_min[ch] = s;
        if (s > chan_max[ch])
            chan_max[ch] = s;
        ch++;
        if (ch < nc)
        begin
            walk_channel = ch;
            return;
        end
        walk_channel = 0;
        pixels_done  = pixels_done + 1'b1;
        if (pixels_done < np)
            return;
        for (int i = 0; i < nc; i++)
        begin
            quotient = chan_sum[i] / SUM_W'(np);
            // mean can only overflow after a mid-frame register change
            if (quotient > SUM_W'(16'hFFFF))
                quotient = SUM_W'(16'hFFFF);
            r.channel       = CH_W'(i);
            r.mean_value    = quotient[DATA_W-1:0];
            r.min_value     = chan_min[i];
            r.max_value     = chan_max[i];
            r.last_of_frame = (i + 1 == nc);
            pending_stats.push_back(r);
        end
        clear_frame_stats();
    endfunction

    function automatic int draw_idle(int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 19);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return DATA_W'($urandom_range(0, 15));
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [PPF_W-1:0] draw_pixel_count();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return {1'b1, 24'($urandom)};
            2: return PPF_W'($urandom_range(9, 40));
            default: return PPF_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic stim_row_t sample_row(logic [DATA_W-1:0] v);
        stim_row_t r;
        r = '{kind: ROW_SAMPLE, index: '0, value: PPF_W'(v), typed: 1'b0, want: '0};
        return r;
    endfunction

    // typed value stands for the final result of the frame this item closes
    function automatic stim_row_t typed_row(logic [DATA_W-1:0] v, int ch,
                                            logic [DATA_W-1:0] mean_v,
                                            logic [DATA_W-1:0] min_v,
                                            logic [DATA_W-1:0] max_v);
        stim_row_t r;
        r = sample_row(v);
        r.typed = 1'b1;
        r.want  = '{CH_W'(ch), mean_v, min_v, max_v, 1'b1};
        return r;
    endfunction

    function automatic stim_row_t config_row(logic [IDX_W-1:0] idx, logic [PPF_W-1:0] v);
        stim_row_t r;
        r = '{kind: ROW_CONFIG, index: idx, value: v, typed: 1'b0, want: '0};
        return r;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [IDX_W-1:0] idx, logic [PPF_W-1:0] data);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        apply_register(idx, data);
    endtask

    // returns at the edge that accepted the item, valid still high
    task automatic send_sample(logic [DATA_W-1:0] value, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (in_stall);
        account_sample(value);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            mon_got = '{channel, mean_value, min_value, max_value, last_of_frame};
            if (pending_stats.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result: channel %0d mean %h min %h max %h last %b",
                             channel, mean_value, min_value, max_value, last_of_frame);
                mismatch_count++;
            end
            else
            begin
                mon_want = pending_stats.pop_front();
                if (mon_got !== mon_want)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display({"mismatch: exp ch %0d mean %h min %h max %h last %b, ",
                                  "got ch %0d mean %h min %h max %h last %b"},
                                 mon_want.channel, mon_want.mean_value, mon_want.min_value,
                                 mon_want.max_value, mon_want.last_of_frame,
                                 mon_got.channel, mon_got.mean_value, mon_got.min_value,
                                 mon_got.max_value, mon_got.last_of_frame);
                    mismatch_count++;
                end
            end
        end
    end

    // result sink: random stalls, plus one long hold-off when asked
    initial
    begin
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            n = draw_idle(out_mode);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                n += LONG_HOLD;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // stimulus
    initial
    begin
        int depth;
        logic [PPF_W-1:0] ppf;

        cfg_channels = 3'd3;
        cfg_pixels   = 25'd1;
        clear_frame_stats();

        // reset settings: three channels, one pixel per frame
        directed_rows.push_back(sample_row(16'h0000));
        directed_rows.push_back(sample_row(16'hFFFF));
        directed_rows.push_back(typed_row(16'hA5A5, 2, 16'hA5A5, 16'hA5A5, 16'hA5A5));
        directed_rows.push_back(config_row(fcs_pkg::REG_CHANNEL_COUNT, 25'd1));
        directed_rows.push_back(typed_row(16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // channel count zero behaves as one
        directed_rows.push_back(config_row(fcs_pkg::REG_CHANNEL_COUNT, 25'd0));
        directed_rows.push_back(typed_row(16'h0000, 0, 16'h0000, 16'h0000, 16'h0000));
        // seven clamps to four channels, two pixels
        directed_rows.push_back(config_row(fcs_pkg::REG_CHANNEL_COUNT, 25'd7));
        directed_rows.push_back(config_row(fcs_pkg::REG_PIXELS_PER_FRAME, 25'd2));
        directed_rows.push_back(sample_row(16'hFFFF));
        directed_rows.push_back(sample_row(16'h0000));
        directed_rows.push_back(sample_row(16'h8000));
        directed_rows.push_back(sample_row(16'h0001));
        directed_rows.push_back(sample_row(16'hFFFF));
        directed_rows.push_back(sample_row(16'h0000));
        directed_rows.push_back(sample_row(16'h7FFF));
        directed_rows.push_back(typed_row(16'hFFFE, 3, 16'h7FFF, 16'h0001, 16'hFFFE));
        // pixel count zero behaves as one
        directed_rows.push_back(config_row(fcs_pkg::REG_CHANNEL_COUNT, 25'd4));
        directed_rows.push_back(config_row(fcs_pkg::REG_PIXELS_PER_FRAME, 25'd0));
        directed_rows.push_back(sample_row(16'h1111));
        directed_rows.push_back(sample_row(16'h2222));
        directed_rows.push_back(sample_row(16'h3333));
        directed_rows.push_back(typed_row(16'h4444, 3, 16'h4444, 16'h4444, 16'h4444));
        // oversized pixel count, then shrink both registers mid-frame
        directed_rows.push_back(config_row(fcs_pkg::REG_PIXELS_PER_FRAME, 25'h1FFFFFF));
        for (int i = 0; i < 7; i++)
            directed_rows.push_back(sample_row(16'h8000));
        directed_rows.push_back(config_row(fcs_pkg::REG_CHANNEL_COUNT, 25'd2));
        directed_rows.push_back(config_row(fcs_pkg::REG_PIXELS_PER_FRAME, 25'd1));
        directed_rows.push_back(sample_row(16'h8000));
        // three samples over one pixel: mean saturates
        directed_rows.push_back(typed_row(16'h8000, 1, 16'hFFFF, 16'h8000, 16'h8000));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_CONFIG)
                write_register(directed_rows[k].index, directed_rows[k].value);
            else
            begin
                depth = pending_stats.size();
                send_sample(directed_rows[k].value[DATA_W-1:0], draw_idle(in_mode));
                if (directed_rows[k].typed && pending_stats.size() > depth)
                begin
                    void'(pending_stats.pop_back());
                    pending_stats.push_back(directed_rows[k].want);
                end
            end
        end

        for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++)
        begin
            in_mode  = blk % 3;
            out_mode = in_mode;
            ppf = draw_pixel_count();
            // hold-off blocks keep frames short so the sink backs up the input
            if (blk == 3 || blk == 7)
            begin
                ppf = PPF_W'($urandom_range(1, 3));
                in_mode = 0;
                long_hold_req = 1'b1;
            end
            write_register(fcs_pkg::REG_CHANNEL_COUNT, PPF_W'($urandom_range(0, 7)));
            write_register(fcs_pkg::REG_PIXELS_PER_FRAME, ppf);
            for (int k = 0; k < BLOCK_ITEMS; k++)
            begin
                if ($urandom_range(0, 29) == 0)
                    wait_drained();
                send_sample(draw_sample(), draw_idle(in_mode));
            end
        end

        wait_drained();
        if (mismatch_count == 0 && pending_stats.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fcs_pkg.sv
rtl/fcs_ctrl.sv
rtl/fcs_datapath.sv
rtl/frame_channel_statistics.sv
sim/frame_channel_statistics_tb.sv
